// File: rtl/lpg_pkg.sv
package lpg_pkg;

   // Breathing ramp
   localparam int unsigned BREATH_PEAK   = 500000;
   localparam int unsigned BREATH_DIV    = (BREATH_PEAK / 100 > 0) ? (BREATH_PEAK / 100) : 1;
   localparam int unsigned BREATH_CNT_W  = 19;
   localparam int unsigned BREATH_PCT_W  = $clog2(BREATH_PEAK / BREATH_DIV + 1);
   localparam int unsigned BREATH_REM_W  = (BREATH_DIV > 1) ? $clog2(BREATH_DIV) : 1;

   // Motion flash timing
   localparam logic [31:0] MOTION_FLASH_TICKS = 32'd100;
   localparam logic [31:0] MOTION_FLASH_HALF  = MOTION_FLASH_TICKS / 32'd2;

   // Duty levels
   localparam int unsigned DUTY_W   = 7;
   localparam logic [6:0]  DUTY_OFF = 7'd0;
   localparam logic [6:0]  DUTY_ON  = 7'd100;

   // Divide by 100: x * ceil(2^30 / 100) >> 30, exact for x below 2^23
   localparam int unsigned DIV100_SHIFT = 30;
   localparam logic [23:0] DIV100_RECIP = 24'd10737419;
   localparam int unsigned PROD_W       = 23;

   // Register reset values
   localparam logic [15:0] FLASH_PERIOD_RESET = 16'd1000;
   localparam logic [15:0] PWM_PERIOD_RESET   = 16'd47999;

   // Register indexes
   localparam logic [1:0] CSR_PATTERN_SEL  = 2'd0;
   localparam logic [1:0] CSR_FLASH_PERIOD = 2'd1;
   localparam logic [1:0] CSR_PWM_PERIOD   = 2'd2;

   typedef enum logic [3:0] {
      MODE_FLASH_ONE    = 4'd0,
      MODE_FLASH_TWO    = 4'd1,
      MODE_FLASH_ALT    = 4'd2,
      MODE_FLASH_BOTH   = 4'd3,
      MODE_ON_ONE       = 4'd4,
      MODE_ON_TWO       = 4'd5,
      MODE_ON_BOTH      = 4'd6,
      MODE_OFF          = 4'd7,
      MODE_BREATH_ONE   = 4'd8,
      MODE_BREATH_TWO   = 4'd9,
      MODE_BREATH_BOTH  = 4'd10,
      MODE_MOTION_FLASH = 4'd11
   } lpg_mode_type;

   typedef struct packed {
      logic [31:0] current_time;
      logic        motion_active;
   } lpg_req_type;

   typedef struct packed {
      logic [6:0]  ch1_percent;
      logic [6:0]  ch2_percent;
      logic [15:0] ch1_compare;
      logic [15:0] ch2_compare;
   } lpg_rsp_type;

endpackage

// File: rtl/lpg_pattern.sv
module lpg_pattern (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lpg_pkg::lpg_req_type      req_data,
   input  lpg_pkg::lpg_mode_type     pattern_sel,
   input  logic [15:0]               flash_period,
   output logic                      duty_valid,
   input  logic                      duty_ready,
   output logic [6:0]                duty_one,
   output logic [6:0]                duty_two
);
   import lpg_pkg::*;

   logic                    accept;
   logic                    valid_ff, valid_in;
   logic [31:0]             stamp_ff, stamp_in;
   logic [BREATH_CNT_W-1:0] count_ff, count_in;
   logic                    rising_ff, rising_in;
   logic [BREATH_REM_W-1:0] rem_ff, rem_in;
   logic [BREATH_PCT_W-1:0] pct_ff, pct_in;
   logic [6:0]              held_one_ff, held_one_in;
   logic [6:0]              held_two_ff, held_two_in;
   logic [6:0]              breath_pct;
   logic [31:0]             elapsed, period32, half32;
   logic                    f_first, f_second, m_first, m_second;

   // Take a word when the duty stage is empty or moving on
   assign req_stall = valid_ff && !duty_ready;
   assign accept    = req_valid && !req_stall;

   // Step the breathing ramp, keeping quotient and remainder by the divisor alongside
   always_comb begin
      if (rising_ff) begin
         count_in = count_ff + BREATH_CNT_W'(1);
         if (rem_ff == BREATH_REM_W'(BREATH_DIV - 1)) begin
            rem_in = '0;
            pct_in = pct_ff + BREATH_PCT_W'(1);
         end else begin
            rem_in = rem_ff + BREATH_REM_W'(1);
            pct_in = pct_ff;
         end
      end else begin
         count_in = count_ff - BREATH_CNT_W'(1);
         if (rem_ff == '0) begin
            rem_in = BREATH_REM_W'(BREATH_DIV - 1);
            pct_in = pct_ff - BREATH_PCT_W'(1);
         end else begin
            rem_in = rem_ff - BREATH_REM_W'(1);
            pct_in = pct_ff;
         end
      end
      if (count_in == BREATH_CNT_W'(BREATH_PEAK)) begin
         rising_in = 1'b0;
      end else if (count_in == '0) begin
         rising_in = 1'b1;
      end else begin
         rising_in = rising_ff;
      end
   end

   assign breath_pct = (pct_in > BREATH_PCT_W'(100)) ? DUTY_ON : DUTY_W'(pct_in);

   // Locate the tick within the flash period
   assign elapsed  = req_data.current_time - stamp_ff;
   assign period32 = {16'd0, flash_period};
   assign half32   = {17'd0, flash_period[15:1]};
   assign f_first  = elapsed < half32;
   assign f_second = (elapsed >= half32) && (elapsed < period32);
   assign m_first  = elapsed < MOTION_FLASH_HALF;
   assign m_second = (elapsed >= MOTION_FLASH_HALF) && (elapsed < MOTION_FLASH_TICKS);

   // Choose the duties for the mode
   always_comb begin
      held_one_in = held_one_ff;
      held_two_in = held_two_ff;
      stamp_in    = stamp_ff;
      case (pattern_sel)
         MODE_FLASH_ONE, MODE_FLASH_TWO, MODE_FLASH_ALT, MODE_FLASH_BOTH: begin
            if (f_second) begin
               held_one_in = (pattern_sel == MODE_FLASH_TWO) ? DUTY_OFF : DUTY_ON;
               held_two_in = (pattern_sel == MODE_FLASH_TWO || pattern_sel == MODE_FLASH_BOTH)
                             ? DUTY_ON : DUTY_OFF;
            end else if (f_first) begin
               held_one_in = DUTY_OFF;
               held_two_in = (pattern_sel == MODE_FLASH_ALT) ? DUTY_ON : DUTY_OFF;
            end else begin
               stamp_in = req_data.current_time;
            end
         end
         MODE_ON_ONE: begin
            held_one_in = DUTY_ON;
            held_two_in = DUTY_OFF;
         end
         MODE_ON_TWO: begin
            held_one_in = DUTY_OFF;
            held_two_in = DUTY_ON;
         end
         MODE_ON_BOTH: begin
            held_one_in = DUTY_ON;
            held_two_in = DUTY_ON;
         end
         MODE_OFF: begin
            held_one_in = DUTY_OFF;
            held_two_in = DUTY_OFF;
         end
         MODE_BREATH_ONE: begin
            held_one_in = breath_pct;
            held_two_in = DUTY_OFF;
         end
         MODE_BREATH_TWO: begin
            held_one_in = DUTY_OFF;
            held_two_in = breath_pct;
         end
         MODE_BREATH_BOTH: begin
            held_one_in = breath_pct;
            held_two_in = breath_pct;
         end
         MODE_MOTION_FLASH: begin
            if (!m_first && !m_second) begin
               held_one_in = DUTY_OFF;
               held_two_in = DUTY_OFF;
               stamp_in    = req_data.current_time;
            end else if (req_data.motion_active) begin
               held_one_in = m_second ? DUTY_ON : DUTY_OFF;
               held_two_in = m_second ? DUTY_ON : DUTY_OFF;
            end
         end
         default: begin
         end
      endcase
   end

   // Stage valid: set on accept, drop once the next stage takes it
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (duty_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Update state on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         stamp_ff    <= '0;
         count_ff    <= '0;
         rising_ff   <= 1'b1;
         rem_ff      <= '0;
         pct_ff      <= '0;
         held_one_ff <= DUTY_OFF;
         held_two_ff <= DUTY_OFF;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            stamp_ff    <= stamp_in;
            count_ff    <= count_in;
            rising_ff   <= rising_in;
            rem_ff      <= rem_in;
            pct_ff      <= pct_in;
            held_one_ff <= held_one_in;
            held_two_ff <= held_two_in;
         end
      end
   end

   // The held duties change only on accept, so they are this stage's payload
   assign duty_valid = valid_ff;
   assign duty_one   = held_one_ff;
   assign duty_two   = held_two_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BREATH_CNT_W'(BREATH_PEAK))
      else $error("breathing count beyond peak");

   a_pct_track: assert property (@(posedge clock) disable iff (reset)
      (32'(pct_ff) * BREATH_DIV + 32'(rem_ff) == 32'(count_ff))
      && (32'(rem_ff) < BREATH_DIV))
      else $error("breathing percent out of step with count");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      held_one_ff <= DUTY_ON && held_two_ff <= DUTY_ON)
      else $error("held duty above full scale");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !duty_ready) |=> (valid_ff && $stable(held_one_ff) && $stable(held_two_ff)))
      else $error("duty stage changed while not taken");

endmodule

// File: rtl/lpg_scale.sv
module lpg_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 duty_valid,
   output logic                 duty_ready,
   input  logic [6:0]           duty_one,
   input  logic [6:0]           duty_two,
   input  logic [15:0]          pwm_period,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpg_pkg::lpg_rsp_type rsp_data
);
   import lpg_pkg::*;

   logic                 prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0]    prod_one_ff, prod_two_ff;
   logic [6:0]           pct_one_ff, pct_two_ff;
   logic                 out_valid_ff, out_valid_in;
   lpg_rsp_type          out_ff;
   logic                 out_ready;
   logic [PROD_W+23:0]   quot_one, quot_two;

   // Output register frees when empty or taken
   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign duty_ready = !prod_valid_ff || out_ready;

   // Advance valid bits
   always_comb begin
      prod_valid_in = duty_ready ? duty_valid : prod_valid_ff;
      out_valid_in  = out_ready ? prod_valid_ff : out_valid_ff;
   end

   // Divide the products by 100 through the reciprocal
   assign quot_one = (PROD_W + 24)'(prod_one_ff) * (PROD_W + 24)'(DIV100_RECIP);
   assign quot_two = (PROD_W + 24)'(prod_two_ff) * (PROD_W + 24)'(DIV100_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Scale percent by the PWM period
   always_ff @(posedge clock) begin
      if (duty_ready && duty_valid) begin
         prod_one_ff <= PROD_W'(pwm_period) * PROD_W'(duty_one);
         prod_two_ff <= PROD_W'(pwm_period) * PROD_W'(duty_two);
         pct_one_ff  <= duty_one;
         pct_two_ff  <= duty_two;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (out_ready && prod_valid_ff) begin
         out_ff.ch1_percent <= pct_one_ff;
         out_ff.ch2_percent <= pct_two_ff;
         out_ff.ch1_compare <= quot_one[DIV100_SHIFT +: 16];
         out_ff.ch2_compare <= quot_two[DIV100_SHIFT +: 16];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.ch1_percent == DUTY_ON) |-> (out_ff.ch1_compare == pwm_period))
      else $error("full duty does not give the period");

   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.ch2_percent == DUTY_OFF) |-> (out_ff.ch2_compare == 16'd0))
      else $error("zero duty gives nonzero compare");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && !out_ready) |=> prod_valid_ff)
      else $error("product stage lost a word");

endmodule

// File: rtl/led_pattern_pwm_generator_core.sv
// Port group   Handshake              Payload
// req_         req_valid / req_stall  lpg_req_type: current_time, motion_active
// rsp_         rsp_valid / rsp_stall  lpg_rsp_type: percents and compare values
// csr_         csr_valid / csr_ready  csr_index (0 mode, 1 flash, 2 pwm), csr_data
//
// One word per cycle unless a stall on rsp_ holds the stages; a taken word is registered in each stage in turn.
// The three register stages are: pattern state, percent times period, divide by 100.
// Synchronous active-high reset; the mode, flash and PWM registers reset to 0, 1000, 47999.
// A stall on rsp_ backs up through the stages and reaches req_stall in the same cycle.
// csr_ready is always high; writes take effect at the next clock edge.
module led_pattern_pwm_generator_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpg_pkg::lpg_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpg_pkg::lpg_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data
);
   import lpg_pkg::*;

   lpg_mode_type pattern_sel_ff;
   logic [15:0]  flash_period_ff;
   logic [15:0]  pwm_period_ff;
   logic         duty_valid;
   logic         duty_ready;
   logic [6:0]   duty_one;
   logic [6:0]   duty_two;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_sel_ff  <= MODE_FLASH_ONE;
         flash_period_ff <= FLASH_PERIOD_RESET;
         pwm_period_ff   <= PWM_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_SEL:  pattern_sel_ff  <= lpg_mode_type'(csr_data[3:0]);
            CSR_FLASH_PERIOD: flash_period_ff <= csr_data;
            CSR_PWM_PERIOD:   pwm_period_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lpg_pattern u_pattern (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .pattern_sel  (pattern_sel_ff),
      .flash_period (flash_period_ff),
      .duty_valid   (duty_valid),
      .duty_ready   (duty_ready),
      .duty_one     (duty_one),
      .duty_two     (duty_two)
   );

   lpg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .duty_valid (duty_valid),
      .duty_ready (duty_ready),
      .duty_one   (duty_one),
      .duty_two   (duty_two),
      .pwm_period (pwm_period_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lpg_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [3:0]  MODE_HOLD_FIRST = 4'd12;
   localparam logic [3:0]  MODE_HOLD_LAST  = 4'd15;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_OVER
   } flash_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lpg_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lpg_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PATTERN_SEL;
   logic [15:0] csr_data = '0;

   // Predicted block state and registers
   logic [3:0]  m_mode   = MODE_FLASH_ONE;
   logic [15:0] m_flash  = FLASH_PERIOD_RESET;
   logic [15:0] m_pwm    = PWM_PERIOD_RESET;
   logic [31:0] m_stamp  = '0;
   logic [18:0] m_breath = '0;
   logic        m_rising = 1'b1;
   logic [6:0]  m_duty1  = DUTY_OFF;
   logic [6:0]  m_duty2  = DUTY_OFF;

   lpg_rsp_type pending_duties [$];
   lpg_rsp_type want_duties;
   logic [31:0] tick_time     = '0;
   int unsigned send_idle_pct = 30;
   int unsigned stall_pct     = 79;
   int unsigned hold_ask      = 0;
   int unsigned hold_left     = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   led_pattern_pwm_generator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Place a tick inside the two-phase window that starts at the stamp
   function automatic flash_phase_type flash_phase(input logic [31:0] now,
                                                   input logic [31:0] period);
      logic [31:0] delta;
      delta = now - m_stamp;
      if (delta < period / 32'd2) return PH_FIRST;
      if (delta < period) return PH_SECOND;
      return PH_OVER;
   endfunction

   // Advance the predicted state by one tick and return the duties it reports
   function automatic lpg_rsp_type next_duties(input lpg_req_type w);
      lpg_rsp_type     r;
      flash_phase_type ph;
      int unsigned     step_div;
      int unsigned     pct_raw;
      logic [6:0]      breath_pct;

      // step the breathing ramp, turning at either end
      if (m_rising) m_breath = m_breath + 19'd1;
      else m_breath = m_breath - 19'd1;
      if (m_breath == BREATH_PEAK) m_rising = 1'b0;
      else if (m_breath == '0) m_rising = 1'b1;
      step_div = BREATH_PEAK / 100;
      if (step_div == 0) step_div = 1;
      pct_raw = m_breath / step_div;
      breath_pct = (pct_raw > 100) ? DUTY_ON : 7'(pct_raw);

      case (m_mode)
         MODE_FLASH_ONE, MODE_FLASH_TWO, MODE_FLASH_ALT, MODE_FLASH_BOTH: begin
            ph = flash_phase(w.current_time, {16'd0, m_flash});
            if (ph == PH_OVER) begin
               m_stamp = w.current_time;
            end else if (ph == PH_SECOND) begin
               m_duty1 = (m_mode == MODE_FLASH_TWO) ? DUTY_OFF : DUTY_ON;
               m_duty2 = (m_mode == MODE_FLASH_TWO || m_mode == MODE_FLASH_BOTH) ?
                         DUTY_ON : DUTY_OFF;
            end else begin
               m_duty1 = DUTY_OFF;
               m_duty2 = (m_mode == MODE_FLASH_ALT) ? DUTY_ON : DUTY_OFF;
            end
         end
         MODE_ON_ONE: begin
            m_duty1 = DUTY_ON;
            m_duty2 = DUTY_OFF;
         end
         MODE_ON_TWO: begin
            m_duty1 = DUTY_OFF;
            m_duty2 = DUTY_ON;
         end
         MODE_ON_BOTH: begin
            m_duty1 = DUTY_ON;
            m_duty2 = DUTY_ON;
         end
         MODE_OFF: begin
            m_duty1 = DUTY_OFF;
            m_duty2 = DUTY_OFF;
         end
         MODE_BREATH_ONE: begin
            m_duty1 = breath_pct;
            m_duty2 = DUTY_OFF;
         end
         MODE_BREATH_TWO: begin
            m_duty1 = DUTY_OFF;
            m_duty2 = breath_pct;
         end
         MODE_BREATH_BOTH: begin
            m_duty1 = breath_pct;
            m_duty2 = breath_pct;
         end
         MODE_MOTION_FLASH: begin
            ph = flash_phase(w.current_time, MOTION_FLASH_TICKS);
            if (ph == PH_OVER) begin
               m_duty1 = DUTY_OFF;
               m_duty2 = DUTY_OFF;
               m_stamp = w.current_time;
            end else if (w.motion_active) begin
               m_duty1 = (ph == PH_SECOND) ? DUTY_ON : DUTY_OFF;
               m_duty2 = m_duty1;
            end
         end
         default: begin
         end
      endcase

      r.ch1_percent = m_duty1;
      r.ch2_percent = m_duty2;
      r.ch1_compare = 16'((32'(m_pwm) * 32'(m_duty1)) / 32'd100);
      r.ch2_compare = 16'((32'(m_pwm) * 32'(m_duty2)) / 32'd100);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         // keep the log readable when everything goes wrong
         if (fail_count < 200)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each taken result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duties.size() == 0) begin
            if (fail_count < 200)
               $display("%0t: result %h with nothing expected, expected none", $time,
                        rsp_data);
            fail_count++;
         end else begin
            want_duties = pending_duties.pop_front();
            check_field("ch1_percent", want_duties.ch1_percent, rsp_data.ch1_percent);
            check_field("ch2_percent", want_duties.ch2_percent, rsp_data.ch2_percent);
            check_field("ch1_compare", want_duties.ch1_compare, rsp_data.ch1_compare);
            check_field("ch2_compare", want_duties.ch2_compare, rsp_data.ch2_compare);
         end
      end
   end

   // Drive the result stall: random, or held for a requested stretch
   always @(posedge clock) begin
      if (hold_ask != 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL led_pattern_pwm_generator_core");
         $finish;
      end
   end

   // Offer one tick word and record its prediction once it is taken
   task automatic send_tick(input logic [31:0] t, input logic motion);
      lpg_req_type w;
      w.current_time  = t;
      w.motion_active = motion;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_time = t;
      pending_duties.push_back(next_duties(w));
   endtask

   // Mostly move time forward in steps sized to the active period
   task automatic send_random_tick();
      logic [31:0] t;
      int unsigned span;
      int unsigned pick;
      span = (m_mode == MODE_MOTION_FLASH) ? 30 : m_flash / 3 + 1;
      pick = $urandom_range(0, 99);
      if (pick < 4) t = $urandom;
      else if (pick < 6) t = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else if (pick < 8) t = tick_time - $urandom_range(1, 50);
      else t = tick_time + $urandom_range(0, span);
      send_tick(t, $urandom_range(0, 99) < 60);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_duties.size() != 0);
   endtask

   // Write all three registers back to back; spare mode bits carry noise
   task automatic write_settings(input logic [3:0] mode, input logic [15:0] flash,
                                 input logic [15:0] pwm);
      logic [1:0]  reg_idx [3];
      logic [15:0] reg_val [3];
      reg_idx = '{CSR_PATTERN_SEL, CSR_FLASH_PERIOD, CSR_PWM_PERIOD};
      reg_val = '{{12'($urandom), mode}, flash, pwm};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_idx[i];
         csr_data  <= reg_val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (reg_idx[i])
            CSR_PATTERN_SEL:  m_mode  = reg_val[i][3:0];
            CSR_FLASH_PERIOD: m_flash = reg_val[i];
            CSR_PWM_PERIOD:   m_pwm   = reg_val[i];
            default: begin
            end
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Registers and phase stamp still at reset: both flash halves and the resync
   task automatic test_reset_defaults();
      send_tick(32'd0, 1'b0);
      send_tick(32'd499, 1'b1);
      send_tick(32'd500, 1'b0);
      send_tick(32'd1000, 1'b1);
   endtask

   // Remaining flash patterns, zero period, and a window across the time wrap
   task automatic test_flash_modes();
      for (int m = MODE_FLASH_TWO; m <= MODE_FLASH_BOTH; m++) begin
         drain_results();
         write_settings(4'(m), 16'd1000, 16'($urandom));
         send_tick(m_stamp, 1'b0);
         send_tick(m_stamp + 32'd500, 1'b1);
      end
      drain_results();
      write_settings(MODE_FLASH_BOTH, 16'd0, 16'd0);
      send_tick(m_stamp + 32'd3, 1'b1);
      drain_results();
      write_settings(MODE_FLASH_ALT, 16'hFFFF, 16'hFFFF);
      send_tick(32'hFFFF_FFF0, 1'b0);
      send_tick(32'h0000_7FF0, 1'b1);
      send_tick(32'hFFFF_FFFF, 1'b0);
   endtask

   // Motion flash: gated halves, then the forced off at period end
   task automatic test_motion_flash();
      drain_results();
      write_settings(MODE_MOTION_FLASH, 16'd1000, 16'd47999);
      send_tick(tick_time + 32'd1000, 1'b0);
      send_tick(m_stamp + 32'd10, 1'b1);
      send_tick(m_stamp + 32'd60, 1'b0);
      send_tick(m_stamp + 32'd60, 1'b1);
      send_tick(m_stamp + 32'd99, 1'b0);
      send_tick(m_stamp + 32'd100, 1'b1);
   endtask

   // Fixed levels at both PWM extremes
   task automatic test_fixed_levels();
      drain_results();
      write_settings(MODE_ON_ONE, 16'd1000, 16'hFFFF);
      send_random_tick();
      drain_results();
      write_settings(MODE_ON_TWO, 16'd1000, 16'd0);
      send_random_tick();
      drain_results();
      write_settings(MODE_OFF, 16'd1000, 16'd333);
      send_random_tick();
      drain_results();
      write_settings(MODE_ON_BOTH, 16'd1000, 16'hFFFF);
      send_random_tick();
   endtask

   // Unused modes hold the duties while the compare follows the new period
   task automatic test_hold_modes();
      drain_results();
      write_settings(MODE_HOLD_FIRST, 16'd1000, 16'd4800);
      send_tick($urandom, 1'b1);
      drain_results();
      write_settings(MODE_HOLD_LAST, 16'd1, 16'd4801);
      send_tick(tick_time + 32'd1, 1'b0);
   endtask

   // Random settings, each followed by a burst of ticks
   task automatic test_random(input int unsigned n);
      int unsigned sent;
      int unsigned burst;
      int unsigned pick;
      logic [3:0]  mode;
      logic [15:0] flash;
      logic [15:0] pwm;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) mode = 4'($urandom_range(MODE_FLASH_ONE, MODE_FLASH_BOTH));
         else if (pick < 6) mode = MODE_MOTION_FLASH;
         else mode = 4'($urandom_range(MODE_ON_ONE, MODE_HOLD_LAST));
         case ($urandom_range(0, 7))
            0: flash = 16'd0;
            1: flash = 16'd1;
            2: flash = 16'hFFFF;
            3: flash = 16'($urandom_range(2, 8));
            4: flash = 16'($urandom);
            default: flash = 16'($urandom_range(2, 400));
         endcase
         case ($urandom_range(0, 3))
            0: pwm = 16'd0;
            1: pwm = 16'hFFFF;
            default: pwm = 16'($urandom);
         endcase
         drain_results();
         write_settings(mode, flash, pwm);
         burst = $urandom_range(10, 60);
         repeat (burst) send_random_tick();
         sent += burst;
      end
   endtask

   // Hold off the result side long enough to back the block up to its input
   task automatic test_backpressure();
      drain_results();
      write_settings(MODE_FLASH_ALT, 16'd20, 16'd100);
      hold_ask = 60;
      repeat (40) send_random_tick();
      drain_results();
   endtask

   // Step the ramp with both channels breathing, then each breathing mode alone
   task automatic test_breath_ramp();
      drain_results();
      write_settings(MODE_BREATH_BOTH, 16'd1000, 16'hFFFF);
      repeat (100) send_tick(tick_time + 32'd1, 1'b0);
      drain_results();
      write_settings(MODE_BREATH_ONE, 16'd1000, 16'd47999);
      repeat (20) send_random_tick();
      drain_results();
      write_settings(MODE_BREATH_TWO, 16'd1000, 16'd1);
      repeat (20) send_random_tick();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_flash_modes();
      test_motion_flash();
      test_fixed_levels();
      test_hold_modes();
      test_random(560);

      // swap the idling sides
      send_idle_pct = 79;
      stall_pct     = 30;
      test_random(560);

      // no idling from here on
      send_idle_pct = 0;
      stall_pct     = 0;
      test_backpressure();
      test_breath_ramp();
      test_random(560);

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS led_pattern_pwm_generator_core");
      else
         $display("FAIL led_pattern_pwm_generator_core");
      $finish;
   end

endmodule
